### design/rmq_pkg.sv
// Package for the range min/max position query block.
// Holds action and status codes, field widths and the command word type.
// Depends on nothing.
`default_nettype none

package rmq_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 11;
    localparam int ACT_W = 2;
    localparam int STS_W = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    localparam logic [STS_W-1:0] STS_DISTINCT = 2'd0;
    localparam logic [STS_W-1:0] STS_EQUAL    = 2'd1;
    localparam logic [STS_W-1:0] STS_INVALID  = 2'd2;

    // One classified command word as it travels from front to back.
    typedef struct packed {
        logic [ACT_W-1:0]        op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        left;
        logic [POS_W-1:0]        right;
    } t_cmd;

endpackage

`default_nettype wire

### design/rmq_if.sv
// Channel interfaces for the request and response words.
// Depends on rmq_pkg for field widths.
`default_nettype none

interface rmq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [rmq_pkg::ACT_W-1:0]            action;
    logic signed [rmq_pkg::VAL_W-1:0]     value;
    logic [rmq_pkg::POS_W-1:0]            left;
    logic [rmq_pkg::POS_W-1:0]            right;
    modport source (output valid, action, value, left, right, input ready);
    modport sink   (input valid, action, value, left, right, output ready);
endinterface

interface rmq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rmq_pkg::STS_W-1:0]     status;
    logic [rmq_pkg::POS_W-1:0]     max_position;
    logic [rmq_pkg::POS_W-1:0]     min_position;
    modport source (output valid, status, max_position, min_position, input ready);
    modport sink   (input valid, status, max_position, min_position, output ready);
endinterface

`default_nettype wire

### design/rmq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
`default_nettype none

module rmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]              o_rdata_a,
    output logic [WIDTH-1:0]              o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and both reads in one clocked block.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/rmq_front.sv
// Front end: accepts request words, drops unknown actions, queues the rest.
// Depends on rmq_pkg and rmq_if.
`default_nettype none

module rmq_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rmq_req_if.sink       i_req,
    output logic          o_cmd_valid,
    output rmq_pkg::t_cmd o_cmd,
    input  wire logic     i_cmd_take
);
    import rmq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_push;
    logic       n_pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign n_push      = i_req.valid && i_req.ready && (i_req.action != ACT_NONE);
    assign n_pop       = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= '{op: i_req.action, value: i_req.value,
                           left: i_req.left, right: i_req.right};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= ~r_wp;
            if (n_pop)  r_rp <= ~r_rp;
            if (n_push && !n_pop)      r_cnt <= r_cnt + 2'd1;
            else if (n_pop && !n_push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

`default_nettype wire

### design/rmq_back.sv
// Back end: element count, sparse table memory, append sequencer and query.
// Depends on rmq_pkg, rmq_if and rmq_ram.
`default_nettype none

module rmq_back #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  rmq_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    rmq_rsp_if.source     o_rsp
);
    import rmq_pkg::*;

    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int JW    = $clog2(LEVELS + 1);
    localparam int DEPTH = MAX_ELEMENTS * LEVELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int EW    = 2 * VAL_W + 2 * CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_L0   = 3'd1;
    localparam logic [2:0] S_ARD  = 3'd2;
    localparam logic [2:0] S_AWR  = 3'd3;
    localparam logic [2:0] S_QRD  = 3'd4;
    localparam logic [2:0] S_QCMP = 3'd5;

    typedef struct packed {
        logic signed [VAL_W-1:0] maxv;
        logic signed [VAL_W-1:0] minv;
        logic [CW-1:0]           maxp;
        logic [CW-1:0]           minp;
    } t_entry;

    logic [2:0]      r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_p;
    logic [JW-1:0]   r_lvl;
    logic [CW-1:0]   r_start;
    t_cmd            r_cmd;
    logic            r_ovalid;
    logic [STS_W-1:0] r_status;
    logic [POS_W-1:0] r_maxp;
    logic [POS_W-1:0] r_minp;

    logic            n_we;
    logic [AW-1:0]   n_waddr;
    t_entry          n_wdata;
    logic [AW-1:0]   n_ra;
    logic [AW-1:0]   n_rb;
    logic [EW-1:0]   w_qa;
    logic [EW-1:0]   w_qb;
    t_entry          w_ea;
    t_entry          w_eb;
    t_entry          n_comb;
    logic            n_more;
    logic [XW-1:0]   n_l;
    logic [XW-1:0]   n_r;
    logic [XW-1:0]   n_len;
    logic [JW-1:0]   n_k;
    logic [XW-1:0]   n_pow;
    logic            n_bad;
    logic [CW-1:0]   n_st;
    logic [CW-1:0]   n_mid;

    // Address of a table entry: level-major, 1-based position.
    function automatic logic [AW-1:0] slot(input logic [JW-1:0] lvl,
                                           input logic [XW-1:0] pos);
        logic [AW+JW-1:0] base;
        logic [XW-1:0]    idx;
        base = (AW + JW)'(lvl) * (AW + JW)'(MAX_ELEMENTS);
        idx  = pos - XW'(1);
        return AW'(base + (AW + JW)'(idx));
    endfunction

    rmq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (n_we),
        .i_waddr   (n_waddr),
        .i_wdata   (n_wdata),
        .i_raddr_a (n_ra),
        .i_raddr_b (n_rb),
        .o_rdata_a (w_qa),
        .o_rdata_b (w_qb)
    );

    assign w_ea = w_qa;
    assign w_eb = w_qb;

    // Merge of two blocks; on a tie the right block wins.
    always_comb begin
        n_comb = w_eb;
        if (w_ea.maxv > w_eb.maxv) begin
            n_comb.maxv = w_ea.maxv;
            n_comb.maxp = w_ea.maxp;
        end
        if (w_ea.minv < w_eb.minv) begin
            n_comb.minv = w_ea.minv;
            n_comb.minp = w_ea.minp;
        end
    end

    // Query range check and level select.
    always_comb begin
        n_l   = XW'(r_cmd.left);
        n_r   = XW'(r_cmd.right);
        n_bad = (n_l == '0) || (n_l > n_r) || (n_r > XW'(r_count));
        n_len = n_r - n_l + XW'(1);
        n_k   = '0;
        for (int i = 1; i < XW; i++) begin
            if (n_len[i]) n_k = JW'(i);
        end
        if (n_k > JW'(LEVELS - 1)) n_k = JW'(LEVELS - 1);
        n_pow = XW'(1) << n_k;
    end

    // Block bounds of the current append level.
    assign n_st   = r_p - CW'(XW'(1) << r_lvl) + CW'(1);
    assign n_mid  = n_st + CW'(XW'(1) << (r_lvl - JW'(1)));
    assign n_more = ((r_lvl + JW'(1)) < JW'(LEVELS))
                    && ((XW'(1) << (r_lvl + JW'(1))) <= XW'(r_p));

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid
                        && !((i_cmd.op == ACT_QUERY) && r_ovalid);

    // Memory port drive for each state.
    always_comb begin
        n_we    = 1'b0;
        n_waddr = slot(r_lvl, XW'(r_start));
        n_wdata = n_comb;
        n_ra    = slot(r_lvl - JW'(1), XW'(n_st));
        n_rb    = slot(r_lvl - JW'(1), XW'(n_mid));
        unique case (r_state)
            S_L0: begin
                n_we    = 1'b1;
                n_waddr = slot('0, XW'(r_p));
                n_wdata = '{maxv: r_cmd.value, minv: r_cmd.value, maxp: r_p, minp: r_p};
            end
            S_AWR: n_we = 1'b1;
            S_QRD: begin
                n_ra = slot(n_k, n_l);
                n_rb = slot(n_k, n_r - n_pow + XW'(1));
            end
            default: ;
        endcase
    end

    // Sequencer, count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.op)
                            ACT_CLEAR: r_count <= '0;
                            ACT_APPEND: begin
                                if (r_count != CW'(MAX_ELEMENTS)) begin
                                    r_p     <= r_count + CW'(1);
                                    r_state <= S_L0;
                                end
                            end
                            ACT_QUERY: r_state <= S_QRD;
                            default: ;
                        endcase
                    end
                end
                S_L0: begin
                    r_lvl <= JW'(1);
                    if (r_p >= CW'(2)) begin
                        r_state <= S_ARD;
                    end else begin
                        r_count <= r_p;
                        r_state <= S_IDLE;
                    end
                end
                S_ARD: begin
                    r_start <= n_st;
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    r_lvl <= r_lvl + JW'(1);
                    if (n_more) begin
                        r_state <= S_ARD;
                    end else begin
                        r_count <= r_p;
                        r_state <= S_IDLE;
                    end
                end
                S_QRD: begin
                    if (n_bad) begin
                        r_ovalid <= 1'b1;
                        r_status <= STS_INVALID;
                        r_maxp   <= '0;
                        r_minp   <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_QCMP;
                    end
                end
                S_QCMP: begin
                    r_ovalid <= 1'b1;
                    if (n_comb.maxv == n_comb.minv) begin
                        r_status <= STS_EQUAL;
                        r_maxp   <= '0;
                        r_minp   <= '0;
                    end else begin
                        r_status <= STS_DISTINCT;
                        r_maxp   <= POS_W'(n_comb.maxp);
                        r_minp   <= POS_W'(n_comb.minp);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_status;
    assign o_rsp.max_position = r_maxp;
    assign o_rsp.min_position = r_minp;

endmodule

`default_nettype wire

### design/range_min_max_position_query.sv
// Range min/max position query over sparse tables of maxima and minima.
// Append runs in the back end as a level-0 write, then one read and one write of the shared
// table memory per further level (up to LEVELS levels in all); clear only resets the count.
// Query reads two table entries and compares them (no compare for an invalid range); one at a time.
// Synchronous active-low reset empties the queue and sets the count to zero; table
// contents are not cleared and need no clearing pass.
`default_nettype none

module range_min_max_position_query #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rmq_req_if.sink   i_req,
    rmq_rsp_if.source o_rsp
);
    import rmq_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;

    rmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    rmq_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // Unknown actions never reach the back end.
    a_no_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> (w_cmd.op != ACT_NONE))
        else $error("unknown action reached back end");

    // Only a non-distinct result carries zero positions.
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STS_DISTINCT))
        |-> (o_rsp.max_position == '0) && (o_rsp.min_position == '0))
        else $error("positions set on non-distinct result");

    // Distinct extremes sit at distinct, nonzero positions.
    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == STS_DISTINCT))
        |-> (o_rsp.max_position != o_rsp.min_position) && (o_rsp.max_position != '0))
        else $error("distinct result with bad positions");
`endif

endmodule

`default_nettype wire
